FILE: rtl/bq_pkg.sv
package bq_pkg;

    localparam int IO_WIDTH           = 32;
    localparam int COEF_WIDTH         = 32;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int DEF_SAMPLE_WIDTH   = 32;
    localparam int DEF_COEF_FRAC_BITS = 30;
    localparam int DEF_STATE_WIDTH    = 48;
    localparam int STEP_WIDTH         = 4;

    // unity gain in q2.30
    localparam logic [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(1) << 30;

    // register map of the configuration port
    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_B0,
        REG_B1,
        REG_B2,
        REG_A1,
        REG_A2
    } reg_index_t;

    typedef enum logic [2:0] {
        COEF_B0,
        COEF_B1,
        COEF_B2,
        COEF_A1,
        COEF_A2
    } coef_sel_t;

    typedef enum logic {
        OPND_X,
        OPND_Y
    } opnd_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD_D1,
        ACC_LOAD_D2,
        ACC_CLEAR,
        ACC_ADD,
        ACC_SUB
    } acc_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_Y,
        WR_D1,
        WR_D2_OUT
    } wr_sel_t;

    typedef enum logic [1:0] {
        JMP_NEXT,
        JMP_WAIT_IN,
        JMP_WAIT_OUT
    } jump_t;

    typedef struct packed {
        logic      load_x;
        logic      mul_en;
        coef_sel_t coef_sel;
        opnd_sel_t opnd_sel;
        acc_op_t   acc_op;
        wr_sel_t   wr_sel;
        jump_t     jump;
    } ctrl_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
    } status_t;

    typedef struct packed {
        logic [COEF_WIDTH-1:0] b0;
        logic [COEF_WIDTH-1:0] b1;
        logic [COEF_WIDTH-1:0] b2;
        logic [COEF_WIDTH-1:0] a1;
        logic [COEF_WIDTH-1:0] a2;
    } coef_t;

    // program addresses
    localparam logic [STEP_WIDTH-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_WIDTH-1:0] STEP_MUL_B0 = 4'd1;
    localparam logic [STEP_WIDTH-1:0] STEP_ACC_B0 = 4'd2;
    localparam logic [STEP_WIDTH-1:0] STEP_WR_Y   = 4'd3;
    localparam logic [STEP_WIDTH-1:0] STEP_ACC_B1 = 4'd4;
    localparam logic [STEP_WIDTH-1:0] STEP_ACC_A1 = 4'd5;
    localparam logic [STEP_WIDTH-1:0] STEP_WR_D1  = 4'd6;
    localparam logic [STEP_WIDTH-1:0] STEP_ACC_B2 = 4'd7;
    localparam logic [STEP_WIDTH-1:0] STEP_ACC_A2 = 4'd8;
    localparam logic [STEP_WIDTH-1:0] STEP_DONE   = 4'd9;

    // microcode rom: each product is registered before the accumulator takes it
    function automatic ctrl_t ucode(input logic [STEP_WIDTH-1:0] step);
        ctrl_t w;
        w          = '0;
        w.coef_sel = COEF_B0;
        w.opnd_sel = OPND_X;
        w.acc_op   = ACC_HOLD;
        w.wr_sel   = WR_NONE;
        w.jump     = JMP_NEXT;
        unique case (step)
            STEP_IDLE:
            begin
                w.load_x = 1'b1;
                w.jump   = JMP_WAIT_IN;
            end
            STEP_MUL_B0:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B0;
                w.acc_op   = ACC_LOAD_D1;
            end
            STEP_ACC_B0:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B1;
                w.acc_op   = ACC_ADD;
            end
            STEP_WR_Y:
            begin
                w.wr_sel = WR_Y;
                w.acc_op = ACC_LOAD_D2;
            end
            STEP_ACC_B1:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A1;
                w.opnd_sel = OPND_Y;
                w.acc_op   = ACC_ADD;
            end
            STEP_ACC_A1:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B2;
                w.acc_op   = ACC_SUB;
            end
            STEP_WR_D1:
            begin
                w.wr_sel = WR_D1;
                w.acc_op = ACC_CLEAR;
            end
            STEP_ACC_B2:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A2;
                w.opnd_sel = OPND_Y;
                w.acc_op   = ACC_ADD;
            end
            STEP_ACC_A2:
            begin
                w.acc_op = ACC_SUB;
            end
            STEP_DONE:
            begin
                w.wr_sel = WR_D2_OUT;
                w.jump   = JMP_WAIT_OUT;
            end
            default:
            begin
                w.jump = JMP_WAIT_OUT;
            end
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/bq_sequencer.sv
module bq_sequencer (
    input  logic            clk,
    input  logic            rst_n,
    input  bq_pkg::status_t status,
    output bq_pkg::ctrl_t   ctrl,
    output logic            in_ready
);
    import bq_pkg::*;

    logic [STEP_WIDTH-1:0] step_reg;
    logic [STEP_WIDTH-1:0] step_next;
    ctrl_t                 word;

    assign word     = ucode(step_reg);
    assign in_ready = (word.jump == JMP_WAIT_IN);

    always_comb
    begin
        ctrl      = word;
        step_next = step_reg + STEP_WIDTH'(1);
        case (word.jump)
            JMP_WAIT_IN:
            begin
                if (!status.in_valid)
                begin
                    step_next   = step_reg;
                    ctrl.load_x = 1'b0;
                end
            end
            JMP_WAIT_OUT:
            begin
                if (status.out_free)
                begin
                    step_next = STEP_IDLE;
                end
                else
                begin
                    step_next   = step_reg;
                    ctrl.wr_sel = WR_NONE;
                end
            end
            default:
            begin
                step_next = step_reg + STEP_WIDTH'(1);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

`ifndef SYNTHESIS
    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_DONE)
        else $error("step counter out of program range");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> step_reg == STEP_IDLE)
        else $error("input ready outside idle step");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ready && status.in_valid) |=> step_reg == STEP_MUL_B0)
        else $error("accepted item did not start the program");
`endif

endmodule

FILE: rtl/bq_datapath.sv
module bq_datapath #(
    parameter int SAMPLE_WIDTH   = bq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = bq_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_WIDTH    = bq_pkg::DEF_STATE_WIDTH
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bq_pkg::ctrl_t               ctrl,
    input  bq_pkg::coef_t               coefs,
    input  logic [bq_pkg::IO_WIDTH-1:0] sample_in,
    input  logic                        out_ready,
    output logic [bq_pkg::IO_WIDTH-1:0] sample_out,
    output logic                        clipped,
    output logic                        out_valid
);
    import bq_pkg::*;

    localparam int PROD_W = COEF_WIDTH + SAMPLE_WIDTH;
    localparam int ACC_W  = ((STATE_WIDTH > PROD_W) ? STATE_WIDTH : PROD_W) + 2;

    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] Y_MIN = ~Y_MAX;
    localparam logic signed [STATE_WIDTH-1:0]  D_MAX = {1'b0, {(STATE_WIDTH-1){1'b1}}};
    localparam logic signed [STATE_WIDTH-1:0]  D_MIN = ~D_MAX;
    localparam logic signed [ACC_W-1:0] Y_MAX_ACC = ACC_W'(Y_MAX);
    localparam logic signed [ACC_W-1:0] Y_MIN_ACC = ACC_W'(Y_MIN);
    localparam logic signed [ACC_W-1:0] D_MAX_ACC = ACC_W'(D_MAX);
    localparam logic signed [ACC_W-1:0] D_MIN_ACC = ACC_W'(D_MIN);

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic                           clip_reg;
    logic signed [PROD_W-1:0]       prod_reg;
    logic signed [ACC_W-1:0]        acc_reg;
    logic signed [ACC_W-1:0]        acc_next;
    logic signed [STATE_WIDTH-1:0]  d1_reg;
    logic signed [STATE_WIDTH-1:0]  d2_reg;
    logic [IO_WIDTH-1:0]            sample_out_reg;
    logic                           clipped_reg;
    logic                           out_valid_reg;

    logic signed [COEF_WIDTH-1:0]   coef_mux;
    logic signed [SAMPLE_WIDTH-1:0] opnd_mux;
    logic signed [PROD_W-1:0]       prod_shift;
    logic signed [ACC_W-1:0]        prod_ext;
    logic signed [SAMPLE_WIDTH-1:0] y_sat;
    logic                           y_clip;
    logic signed [STATE_WIDTH-1:0]  d_sat;

    always_comb
    begin
        case (ctrl.coef_sel)
            COEF_B0: coef_mux = coefs.b0;
            COEF_B1: coef_mux = coefs.b1;
            COEF_B2: coef_mux = coefs.b2;
            COEF_A1: coef_mux = coefs.a1;
            COEF_A2: coef_mux = coefs.a2;
            default: coef_mux = coefs.b0;
        endcase
    end

    assign opnd_mux   = (ctrl.opnd_sel == OPND_Y) ? y_reg : x_reg;
    // floor shift of the product
    assign prod_shift = prod_reg >>> COEF_FRAC_BITS;
    assign prod_ext   = ACC_W'(prod_shift);

    always_comb
    begin
        case (ctrl.acc_op)
            ACC_LOAD_D1: acc_next = ACC_W'(d1_reg);
            ACC_LOAD_D2: acc_next = ACC_W'(d2_reg);
            ACC_CLEAR:   acc_next = '0;
            ACC_ADD:     acc_next = acc_reg + prod_ext;
            ACC_SUB:     acc_next = acc_reg - prod_ext;
            default:     acc_next = acc_reg;
        endcase
    end

    // clamp to sample range and to state range
    always_comb
    begin
        y_clip = 1'b1;
        if (acc_reg > Y_MAX_ACC)
        begin
            y_sat = Y_MAX;
        end
        else if (acc_reg < Y_MIN_ACC)
        begin
            y_sat = Y_MIN;
        end
        else
        begin
            y_sat  = acc_reg[SAMPLE_WIDTH-1:0];
            y_clip = 1'b0;
        end

        if (acc_reg > D_MAX_ACC)
        begin
            d_sat = D_MAX;
        end
        else if (acc_reg < D_MIN_ACC)
        begin
            d_sat = D_MIN;
        end
        else
        begin
            d_sat = acc_reg[STATE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_x)
        begin
            x_reg <= sample_in[SAMPLE_WIDTH-1:0];
        end
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(coef_mux) * PROD_W'(opnd_mux);
        end
        acc_reg <= acc_next;
        if (ctrl.wr_sel == WR_Y)
        begin
            y_reg    <= y_sat;
            clip_reg <= y_clip;
        end
        if (ctrl.wr_sel == WR_D2_OUT)
        begin
            sample_out_reg <= IO_WIDTH'(y_reg);
            clipped_reg    <= clip_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg        <= '0;
            d2_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_sel == WR_D1)
            begin
                d1_reg <= d_sat;
            end
            if (ctrl.wr_sel == WR_D2_OUT)
            begin
                d2_reg        <= d_sat;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sample_out = sample_out_reg;
    assign clipped    = clipped_reg;
    assign out_valid  = out_valid_reg;

`ifndef SYNTHESIS
    a_clip_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && clipped) |->
            (sample_out == IO_WIDTH'(Y_MAX) || sample_out == IO_WIDTH'(Y_MIN)))
        else $error("clipped item is not at a range limit");

    a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr_sel == WR_D2_OUT) |=> out_valid)
        else $error("finished item not presented");
`endif

endmodule

FILE: rtl/biquad_iir_filter_top.sv
// biquad section, transposed direct form ii, one shared multiply-accumulate unit
// an accepted item runs the compute steps in order; the last step writes its result to the output register
// the microprogram has 10 steps (idle + 9 compute steps); items are accepted only in the idle step, one at a time
// a finished result is held in the output register; the next item may be accepted meanwhile
// the last step of an item waits while the output register still holds an untaken result
// reset: coefficients to unity pass-through, delay state zero, no result pending
module biquad_iir_filter_top #(
    parameter int SAMPLE_WIDTH   = bq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = bq_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_WIDTH    = bq_pkg::DEF_STATE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // input item channel
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bq_pkg::IO_WIDTH-1:0]        sample_in,
    // result item channel
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bq_pkg::IO_WIDTH-1:0]        sample_out,
    output logic                               clipped,
    // coefficient write channel
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bq_pkg::COEF_WIDTH-1:0]      cfg_data
);
    import bq_pkg::*;

    coef_t   coef_reg;
    status_t status;
    ctrl_t   ctrl;

    // coefficient writes are always taken; the user must issue them only while idle, the block does not enforce this
    assign cfg_ready = 1'b1;

    // indexes beyond the register map are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.b0 <= B0_RESET;
            coef_reg.b1 <= '0;
            coef_reg.b2 <= '0;
            coef_reg.a1 <= '0;
            coef_reg.a2 <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_B0:  coef_reg.b0 <= cfg_data;
                REG_B1:  coef_reg.b1 <= cfg_data;
                REG_B2:  coef_reg.b2 <= cfg_data;
                REG_A1:  coef_reg.a1 <= cfg_data;
                REG_A2:  coef_reg.a2 <= cfg_data;
                default: coef_reg.a2 <= coef_reg.a2;
            endcase
        end
    end

    // output register is free when empty or being drained this cycle
    assign status.in_valid = in_valid;
    assign status.out_free = !out_valid || out_ready;

    // step counter and microcode rom
    bq_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .status   (status),
        .ctrl     (ctrl),
        .in_ready (in_ready)
    );

    // multiplier, accumulator, saturation, delay state and output register
    bq_datapath #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .STATE_WIDTH    (STATE_WIDTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .coefs      (coef_reg),
        .sample_in  (sample_in),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped),
        .out_valid  (out_valid)
    );

endmodule

FILE: dv/biquad_checker.sv
module biquad_checker #(
    parameter int SAMPLE_WIDTH   = bq_pkg::DEF_SAMPLE_WIDTH,
    parameter int COEF_FRAC_BITS = bq_pkg::DEF_COEF_FRAC_BITS,
    parameter int STATE_WIDTH    = bq_pkg::DEF_STATE_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [bq_pkg::IO_WIDTH-1:0]        sample_in,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic [bq_pkg::IO_WIDTH-1:0]        sample_out,
    input  logic                               clipped,
    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bq_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [bq_pkg::COEF_WIDTH-1:0]      cfg_data,
    output int                                 mismatches,
    output int                                 outstanding
);
    import bq_pkg::*;

    typedef struct packed {
        logic [IO_WIDTH-1:0] sample;
        logic                clip;
    } filtered_t;

    filtered_t pending_outputs[$];
    coef_t     coefs;
    longint    z1;
    longint    z2;
    int        fail_total;

    function automatic longint saturate(input longint v, input int w, inout bit hit);
        longint hi;
        longint lo;
        if (w >= 64)
            return v;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
        begin
            hit = 1'b1;
            return hi;
        end
        if (v < lo)
        begin
            hit = 1'b1;
            return lo;
        end
        return v;
    endfunction

    // q2.30 coefficient times operand, floor division by the fraction scale
    function automatic longint scaled(input logic [COEF_WIDTH-1:0] c, input longint v);
        longint p;
        p = longint'($signed(c)) * v;
        return p >>> COEF_FRAC_BITS;
    endfunction

    function automatic filtered_t next_filtered_sample(input logic [IO_WIDTH-1:0] raw);
        longint x;
        longint y;
        longint n1;
        longint n2;
        bit     clip;
        bit     spill;
        clip  = 1'b0;
        spill = 1'b0;
        x = longint'(raw) <<< (64 - SAMPLE_WIDTH);
        x = x >>> (64 - SAMPLE_WIDTH);
        y  = saturate(scaled(coefs.b0, x) + z1, SAMPLE_WIDTH, clip);
        n1 = saturate(scaled(coefs.b1, x) - scaled(coefs.a1, y) + z2, STATE_WIDTH, spill);
        n2 = saturate(scaled(coefs.b2, x) - scaled(coefs.a2, y), STATE_WIDTH, spill);
        z1 = n1;
        z2 = n2;
        return '{sample: IO_WIDTH'(y), clip: clip};
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        filtered_t want;
        if (!rst_n)
        begin
            pending_outputs.delete();
            coefs      = '0;
            coefs.b0   = B0_RESET;
            z1         = 0;
            z2         = 0;
            fail_total = 0;
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_outputs.size() == 0)
                begin
                    $display("%0t: unexpected result item, sample_out %h clipped %b",
                             $time, sample_out, clipped);
                    fail_total++;
                end
                else
                begin
                    want = pending_outputs.pop_front();
                    if (sample_out !== want.sample)
                    begin
                        $display("%0t: sample_out expected %h actual %h",
                                 $time, want.sample, sample_out);
                        fail_total++;
                    end
                    if (clipped !== want.clip)
                    begin
                        $display("%0t: clipped expected %b actual %b",
                                 $time, want.clip, clipped);
                        fail_total++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (reg_index_t'(cfg_index))
                    REG_B0: coefs.b0 = cfg_data;
                    REG_B1: coefs.b1 = cfg_data;
                    REG_B2: coefs.b2 = cfg_data;
                    REG_A1: coefs.a1 = cfg_data;
                    REG_A2: coefs.a2 = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                pending_outputs.push_back(next_filtered_sample(sample_in));
            mismatches  <= fail_total;
            outstanding <= pending_outputs.size();
        end
    end

endmodule

FILE: dv/tb_top.sv
module tb_top;

    import bq_pkg::*;

    localparam int PHASES          = 10;
    localparam int ITEMS_PER_PHASE = 150;
    localparam int SETTLE_CYCLES   = 12;   // margin beyond the time to finish an item

    localparam logic [COEF_WIDTH-1:0] COEF_MAX = 32'h7fff_ffff;
    localparam logic [COEF_WIDTH-1:0] COEF_MIN = 32'h8000_0000;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                       in_valid  = 1'b0;
    logic                       in_ready;
    logic [IO_WIDTH-1:0]        sample_in = '0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [IO_WIDTH-1:0]        sample_out;
    logic                       clipped;
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = REG_B0;
    logic [COEF_WIDTH-1:0]      cfg_data  = '0;

    int check_errors;
    int outstanding;

    // odds of an idle burst after each item; zero means no idling
    int idle_odds  = 0;
    int stall_odds = 0;

    // full scale, most negative, zero, lsb, minus one, alternating patterns
    logic [IO_WIDTH-1:0] corner_samples [7] = '{
        32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'h0000_0001,
        32'hffff_ffff, 32'h5555_5555, 32'haaaa_aaaa
    };

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    biquad_iir_filter_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .sample_out (sample_out),
        .clipped    (clipped),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    biquad_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .sample_in   (sample_in),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .sample_out  (sample_out),
        .clipped     (clipped),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (check_errors),
        .outstanding (outstanding)
    );

    // receiver back-pressure: random stall bursts with out_ready held low
    always @(posedge clk)
    begin
        int stall_left;
        if (stall_left > 0)
        begin
            stall_left--;
            out_ready <= 1'b0;
        end
        else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
        begin
            stall_left = $urandom_range(1, 19) - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // valid stays up after acceptance unless an idle burst follows,
    // so back-to-back items never lower and raise valid in one step
    task automatic push_sample(input logic [IO_WIDTH-1:0] v);
        in_valid  <= 1'b1;
        sample_in <= v;
        do
            @(posedge clk);
        while (!in_ready);
        if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // hold off the sender until every result item has been taken
    task automatic drain_results;
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it after the last write of a group
    task automatic write_coef(input logic [CFG_INDEX_WIDTH-1:0] idx,
                              input logic [COEF_WIDTH-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_coefs(input coef_t c);
        drain_results();
        write_coef(REG_B0, c.b0);
        write_coef(REG_B1, c.b1);
        write_coef(REG_B2, c.b2);
        write_coef(REG_A1, c.a1);
        write_coef(REG_A2, c.a2);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [COEF_WIDTH-1:0] wild_word();
        case ($urandom_range(0, 5))
            0: return COEF_MAX;
            1: return COEF_MIN;
            default: return $urandom;
        endcase
    endfunction

    // arbitrary coefficients, mostly driving the output into saturation
    function automatic coef_t wild_coefs();
        coef_t c;
        c.b0 = wild_word();
        c.b1 = wild_word();
        c.b2 = wild_word();
        c.a1 = wild_word();
        c.a2 = wild_word();
        return c;
    endfunction

    // poles kept inside the stability triangle: |a2| < 0.9, |a1| <= 0.9 * (1 + a2)
    function automatic coef_t stable_coefs();
        coef_t  c;
        longint a2;
        longint lim;
        a2  = longint'($urandom_range(0, 2 * 966367641)) - 966367641;
        lim = ((longint'(1) <<< 30) + a2) / 10 * 9;
        c.a2 = COEF_WIDTH'(a2);
        c.a1 = COEF_WIDTH'(longint'($urandom_range(0, 32'(2 * lim))) - lim);
        c.b0 = COEF_WIDTH'(longint'($urandom_range(0, 1 << 30)) - (1 << 29));
        c.b1 = COEF_WIDTH'(longint'($urandom_range(0, 1 << 30)) - (1 << 29));
        c.b2 = COEF_WIDTH'(longint'($urandom_range(0, 1 << 30)) - (1 << 29));
        return c;
    endfunction

    function automatic logic [IO_WIDTH-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return corner_samples[$urandom_range(0, 6)];
            1, 2: return IO_WIDTH'(int'($urandom_range(0, 8191)) - 4096);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        coef_t setting;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        idle_odds  = 4;
        stall_odds = 4;

        // reset coefficients give unity pass-through
        foreach (corner_samples[i])
            push_sample(corner_samples[i]);

        // every coefficient at an extreme, output clips hard
        setting.b0 = COEF_MAX;
        setting.b1 = COEF_MIN;
        setting.b2 = COEF_MAX;
        setting.a1 = COEF_MIN;
        setting.a2 = COEF_MAX;
        load_coefs(setting);
        for (int i = 0; i < 6; i++)
            push_sample(corner_samples[i]);

        // unused register indexes must be ignored; delay state carries over
        drain_results();
        for (int i = int'(REG_A2) + 1; i < (1 << CFG_INDEX_WIDTH); i++)
            write_coef(CFG_INDEX_WIDTH'(i), $urandom);
        write_coef(REG_B0, COEF_MIN);
        cfg_valid <= 1'b0;
        for (int i = 0; i < 4; i++)
            push_sample(corner_samples[i]);

        load_coefs(stable_coefs());
        repeat (6) push_sample(random_sample());

        // random phases, each with its own coefficients and idling odds
        for (int phase = 0; phase < PHASES; phase++)
        begin
            // one stretch mid-run and the final phase run with no idling
            if (phase == 3 || phase == PHASES - 1)
            begin
                idle_odds  = 0;
                stall_odds = 0;
            end
            else
            begin
                idle_odds  = $urandom_range(3, 12);
                stall_odds = $urandom_range(3, 12);
            end
            case (phase % 4)
                0: load_coefs(wild_coefs());
                2:
                begin
                    // rewrite one register only, the rest and the delay state stay
                    setting = stable_coefs();
                    drain_results();
                    write_coef(CFG_INDEX_WIDTH'($urandom_range(int'(REG_B0), int'(REG_A2))),
                               setting.a1);
                    cfg_valid <= 1'b0;
                end
                default: load_coefs(stable_coefs());
            endcase
            repeat (ITEMS_PER_PHASE) push_sample(random_sample());
        end

        drain_results();
        if (check_errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #8000000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/bq_pkg.sv
rtl/bq_sequencer.sv
rtl/bq_datapath.sv
rtl/biquad_iir_filter_top.sv
dv/biquad_checker.sv
dv/tb_top.sv
